>>> sv/rcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcp_pkg: shared definitions for the rectangle canvas painter
// Field widths, beat layout, command and status codes, register indexes and
// the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rcp_pkg;

   // Field widths
   localparam int COORD_W      = 20;
   localparam int CHAR_W       = 8;
   localparam int CMD_W        = 2;
   localparam int STATUS_W     = 2;
   localparam int RC_W         = 9;
   localparam int SIDE_REG_W   = 10;
   localparam int WIDE_W       = SIDE_REG_W + 1;

   // Configuration port
   localparam int CSR_ADDR_W   = 2;
   localparam int CSR_DATA_W   = 10;

   // Defaults
   localparam int DEF_MAX_SIDE  = 512;
   localparam int DEF_FRAC_BITS = 8;
   localparam logic [SIDE_REG_W-1:0] RST_CANVAS_WIDTH  = 10'd300;
   localparam logic [SIDE_REG_W-1:0] RST_CANVAS_HEIGHT = 10'd300;
   localparam logic [CHAR_W-1:0]     RST_BACKGROUND    = 8'd32;

   // Request beat layout, lowest bit first
   localparam int REQ_LEFT_LSB   = 0;
   localparam int REQ_TOP_LSB    = REQ_LEFT_LSB + COORD_W;
   localparam int REQ_WIDTH_LSB  = REQ_TOP_LSB + COORD_W;
   localparam int REQ_HEIGHT_LSB = REQ_WIDTH_LSB + COORD_W;
   localparam int REQ_CHAR_LSB   = REQ_HEIGHT_LSB + COORD_W;
   localparam int REQ_COL_LSB    = REQ_CHAR_LSB + CHAR_W;
   localparam int REQ_ROW_LSB    = REQ_COL_LSB + RC_W;
   localparam int REQ_TDATA_W    = 112;
   localparam int REQ_TUSER_W    = CMD_W + 1;
   localparam int REQ_OUTLINE_BIT = CMD_W;

   // Response beat layout
   localparam int RSP_TDATA_W    = CHAR_W;
   localparam int RSP_TUSER_W    = STATUS_W;

   // Command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR = 2'd0,
      CMD_DRAW  = 2'd1,
      CMD_READ  = 2'd2
   } cmd_code_type;

   // Response status codes
   typedef enum logic [STATUS_W-1:0] {
      RSP_DONE   = 2'd0,
      RSP_PIXEL  = 2'd1,
      RSP_REJECT = 2'd2
   } rsp_status_type;

   // Register indexes
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_CANVAS_WIDTH  = 2'd0,
      CSR_CANVAS_HEIGHT = 2'd1,
      CSR_BACKGROUND    = 2'd2
   } csr_index_type;

   // Controller to datapath
   typedef struct packed {
      logic load_item;
      logic calc_bounds;
      logic calc_inner;
      logic sweep;
      logic read;
      logic load_rsp;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic reject;
      logic empty;
      logic sweep_last;
   } dp_status_type;

endpackage

>>> sv/rcp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcp_ctrl: command sequencer
// Accepts one request beat at a time, steps the datapath through bound setup,
// canvas sweep or pixel read, and hands the result to the response register.
// ----------------------------------------------------------------------------
module rcp_ctrl import rcp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [CMD_W-1:0]     req_cmd,
   input  dp_status_type        stat,
   output dp_cmd_type           cmd,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_CALC   = 6'b000010,
      ST_CALC2  = 6'b000100,
      ST_SWEEP  = 6'b001000,
      ST_READ   = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   // Next state and datapath commands
   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.load_item   = accept;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  CMD_CLEAR: state_in = stat.empty ? ST_FINISH : ST_SWEEP;
                  CMD_DRAW:  state_in = ST_CALC;
                  CMD_READ:  state_in = ST_READ;
                  default:   state_in = ST_FINISH;
               endcase
            end
         end
         ST_CALC: begin
            cmd.calc_bounds = 1'b1;
            state_in        = ST_CALC2;
         end
         ST_CALC2: begin
            cmd.calc_inner = 1'b1;
            state_in       = (stat.reject || stat.empty) ? ST_FINISH : ST_SWEEP;
         end
         ST_SWEEP: begin
            cmd.sweep = 1'b1;
            if (stat.sweep_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Response valid: set on load, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> sv/rcp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcp_datapath: canvas memory, configuration registers and sweep logic
// Holds the captured request, the rectangle bounds in fixed point, the column
// and row sweep counters, the canvas memory and the response register.
// ----------------------------------------------------------------------------
module rcp_datapath import rcp_pkg::*; #(
   parameter int MAX_SIDE  = DEF_MAX_SIDE,
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wen,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   input  dp_cmd_type             cmd,
   output dp_status_type          stat,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic [RSP_TUSER_W-1:0] rsp_tuser
);

   localparam int SIDE_BITS = $clog2(MAX_SIDE);
   localparam int CNT_W     = $clog2(MAX_SIDE + 1);
   localparam int ADDR_W    = 2 * SIDE_BITS;
   localparam int MEM_DEPTH = 1 << ADDR_W;
   localparam int CMP_A     = COORD_W + 3;
   localparam int CMP_B     = SIDE_BITS + FRAC_BITS + 2;
   localparam int CMP_W     = (CMP_A > CMP_B) ? CMP_A : CMP_B;
   localparam logic signed [CMP_W-1:0] ONE = CMP_W'(1) <<< FRAC_BITS;

   // Configuration registers
   logic [SIDE_REG_W-1:0] canvas_width_ff;
   logic [SIDE_REG_W-1:0] canvas_height_ff;
   logic [CHAR_W-1:0]     background_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         canvas_width_ff  <= RST_CANVAS_WIDTH;
         canvas_height_ff <= RST_CANVAS_HEIGHT;
         background_ff    <= RST_BACKGROUND;
      end else if (csr_wen) begin
         case (csr_addr)
            CSR_CANVAS_WIDTH:  canvas_width_ff  <= csr_wdata[SIDE_REG_W-1:0];
            CSR_CANVAS_HEIGHT: canvas_height_ff <= csr_wdata[SIDE_REG_W-1:0];
            CSR_BACKGROUND:    background_ff    <= csr_wdata[CHAR_W-1:0];
            default: ;
         endcase
      end
   end

   // Saturate the canvas size to the memory side
   logic [WIDE_W-1:0] cols_wide;
   logic [WIDE_W-1:0] rows_wide;
   logic [CNT_W-1:0]  cols;
   logic [CNT_W-1:0]  rows;

   assign cols_wide = (WIDE_W'(canvas_width_ff) > WIDE_W'(MAX_SIDE)) ?
                      WIDE_W'(MAX_SIDE) : WIDE_W'(canvas_width_ff);
   assign rows_wide = (WIDE_W'(canvas_height_ff) > WIDE_W'(MAX_SIDE)) ?
                      WIDE_W'(MAX_SIDE) : WIDE_W'(canvas_height_ff);
   assign cols      = CNT_W'(cols_wide);
   assign rows      = CNT_W'(rows_wide);
   assign stat.empty = (cols == '0) || (rows == '0);

   // Captured request
   logic [CMD_W-1:0]        cmd_ff;
   logic                    outline_ff;
   logic signed [CMP_W-1:0] left_ff;
   logic signed [CMP_W-1:0] top_ff;
   logic signed [CMP_W-1:0] width_ff;
   logic signed [CMP_W-1:0] height_ff;
   logic [CHAR_W-1:0]       char_ff;
   logic [RC_W-1:0]         col_ff;
   logic [RC_W-1:0]         row_ff;

   logic signed [COORD_W-1:0] req_left;
   logic signed [COORD_W-1:0] req_top;
   logic signed [COORD_W-1:0] req_width;
   logic signed [COORD_W-1:0] req_height;

   assign req_left   = req_tdata[REQ_LEFT_LSB +: COORD_W];
   assign req_top    = req_tdata[REQ_TOP_LSB +: COORD_W];
   assign req_width  = req_tdata[REQ_WIDTH_LSB +: COORD_W];
   assign req_height = req_tdata[REQ_HEIGHT_LSB +: COORD_W];

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         cmd_ff     <= req_tuser[CMD_W-1:0];
         outline_ff <= req_tuser[REQ_OUTLINE_BIT];
         left_ff    <= CMP_W'(req_left);
         top_ff     <= CMP_W'(req_top);
         width_ff   <= CMP_W'(req_width);
         height_ff  <= CMP_W'(req_height);
         char_ff    <= req_tdata[REQ_CHAR_LSB +: CHAR_W];
         col_ff     <= req_tdata[REQ_COL_LSB +: RC_W];
         row_ff     <= req_tdata[REQ_ROW_LSB +: RC_W];
      end
   end

   // Rectangle bounds, set up by calc_bounds and then calc_inner
   logic signed [CMP_W-1:0] right_ff;
   logic signed [CMP_W-1:0] bottom_ff;
   logic signed [CMP_W-1:0] left_p1_ff;
   logic signed [CMP_W-1:0] top_p1_ff;
   logic signed [CMP_W-1:0] right_m1_ff;
   logic signed [CMP_W-1:0] bottom_m1_ff;
   logic                    reject_ff;

   always_ff @(posedge clock) begin
      if (cmd.calc_bounds) begin
         right_ff   <= left_ff + width_ff;
         bottom_ff  <= top_ff + height_ff;
         left_p1_ff <= left_ff + ONE;
         top_p1_ff  <= top_ff + ONE;
         reject_ff  <= (width_ff < ONE) || (height_ff < ONE);
      end
      if (cmd.calc_inner) begin
         right_m1_ff  <= right_ff - ONE;
         bottom_m1_ff <= bottom_ff - ONE;
      end
   end

   assign stat.reject = reject_ff;

   // Sweep counters: column inner, row outer, with fixed-point positions
   logic [SIDE_BITS-1:0]    c_ff;
   logic [SIDE_BITS-1:0]    r_ff;
   logic signed [CMP_W-1:0] px_ff;
   logic signed [CMP_W-1:0] py_ff;
   logic                    c_last;
   logic                    r_last;

   assign c_last = (CNT_W'(c_ff) == (cols - CNT_W'(1)));
   assign r_last = (CNT_W'(r_ff) == (rows - CNT_W'(1)));
   assign stat.sweep_last = c_last && r_last;

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         c_ff  <= '0;
         r_ff  <= '0;
         px_ff <= '0;
         py_ff <= '0;
      end else if (cmd.sweep) begin
         if (c_last) begin
            c_ff  <= '0;
            px_ff <= '0;
            r_ff  <= r_ff + SIDE_BITS'(1);
            py_ff <= py_ff + ONE;
         end else begin
            c_ff  <= c_ff + SIDE_BITS'(1);
            px_ff <= px_ff + ONE;
         end
      end
   end

   // Pixel hit test
   logic row_in;
   logic col_in;
   logic interior;
   logic side_hit;
   logic hit;
   logic is_clear;
   logic [CHAR_W-1:0] wr_char;

   assign row_in   = (py_ff >= top_ff) && (py_ff <= bottom_ff);
   assign col_in   = (px_ff >= left_ff) && (px_ff <= right_ff);
   assign interior = outline_ff && (py_ff >= top_p1_ff) && (py_ff <= bottom_m1_ff);
   assign side_hit = ((px_ff < left_p1_ff) && (px_ff >= left_ff)) ||
                     ((px_ff <= right_ff) && (px_ff > right_m1_ff));
   assign is_clear = (cmd_ff == CMD_CLEAR);
   assign hit      = is_clear || (interior ? side_hit : (row_in && col_in));
   assign wr_char  = is_clear ? background_ff : char_ff;

   // Canvas memory, one write and one registered read port
   logic [CHAR_W-1:0] canvas_mem [MEM_DEPTH];
   logic [CHAR_W-1:0] mem_q_ff;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [WIDE_W-1:0] rd_col_wide;
   logic [WIDE_W-1:0] rd_row_wide;

   assign rd_col_wide = WIDE_W'(col_ff);
   assign rd_row_wide = WIDE_W'(row_ff);
   assign wr_addr     = {r_ff, c_ff};
   assign rd_addr     = {rd_row_wide[SIDE_BITS-1:0], rd_col_wide[SIDE_BITS-1:0]};

   always_ff @(posedge clock) begin
      if (cmd.sweep && hit) begin
         canvas_mem[wr_addr] <= wr_char;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         mem_q_ff <= canvas_mem[rd_addr];
      end
   end

   // Response register
   logic                   in_range;
   logic                   read_ok;
   logic [RSP_TDATA_W-1:0] rsp_tdata_ff;
   logic [RSP_TUSER_W-1:0] rsp_tuser_ff;
   rsp_status_type         status_code;

   assign in_range = (rd_col_wide < WIDE_W'(cols)) && (rd_row_wide < WIDE_W'(rows));
   assign read_ok  = (cmd_ff == CMD_READ) && in_range;

   always_comb begin
      if (read_ok) begin
         status_code = RSP_PIXEL;
      end else if ((cmd_ff == CMD_DRAW) && reject_ff) begin
         status_code = RSP_REJECT;
      end else begin
         status_code = RSP_DONE;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_tuser_ff <= status_code;
         rsp_tdata_ff <= read_ok ? mem_q_ff : '0;
      end
   end

   assign rsp_tdata = rsp_tdata_ff;
   assign rsp_tuser = rsp_tuser_ff;

endmodule

>>> sv/rectangle_canvas_painter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rectangle_canvas_painter_top: byte canvas with clear, rectangle and read
// Keeps a MAX_SIDE by MAX_SIDE byte canvas and answers every request beat
// with one response beat.
// ----------------------------------------------------------------------------
// The block takes one request at a time. Clear and draw walk the whole canvas
// in use, one pixel per cycle through the single write port of the canvas
// memory. A draw first sets up its bounds in the calc_bounds and calc_inner
// states; a rejected draw or a draw on an empty canvas stops there. A clear
// of an empty canvas or an unused command goes straight to the response, and
// a read passes through the registered memory read. A finished
// response waits in an output register; the next request is taken as soon as
// the current one has handed its response over. The canvas is not cleared by
// reset: pixels read back undefined until a clear or a draw has written them.
// Configuration writes are meant to happen only while no request is in work.
module rectangle_canvas_painter_top import rcp_pkg::*; #(
   parameter int MAX_SIDE  = DEF_MAX_SIDE,
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   // configuration write port
   input  logic                   csr_wen,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // rect_left, rect_top, rect_width, rect_height, paint_char, read_column,
   // read_row, zero fill
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // command, outline_only
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   // response channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // pixel_value
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // status
   output logic [RSP_TUSER_W-1:0] rsp_tuser
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_stat;

   rcp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_cmd    (req_tuser[CMD_W-1:0]),
      .stat       (dp_stat),
      .cmd        (dp_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   rcp_datapath #(
      .MAX_SIDE  (MAX_SIDE),
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd       (dp_cmd),
      .stat      (dp_stat),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

>>> dv/tb_rectangle_canvas_painter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rectangle_canvas_painter_top: self-checking bench for the canvas painter
// Sends directed and random clear, draw, read and unused requests over several
// canvas settings, with random idling on both channels and one long response
// hold-off. A canvas predictor gives each expected beat the table leaves open.
// ----------------------------------------------------------------------------
module tb_rectangle_canvas_painter_top;
   import rcp_pkg::*;

   localparam int MAX_SIDE      = DEF_MAX_SIDE;
   localparam int FRAC_BITS     = DEF_FRAC_BITS;
   localparam int ONE_UNIT      = 1 << FRAC_BITS;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int IDLE_PCT      = 27;
   localparam int HOLD_CYCLES   = 2000;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES  = 20;
   localparam int MAX_REPORTS   = 10;
   // the limit covers three full 512 by 512 sweeps
   localparam int WATCHDOG_LIMIT = 800_000;

   typedef struct packed {
      logic [CMD_W-1:0]          cmd;
      logic                      outline;
      logic signed [COORD_W-1:0] left;
      logic signed [COORD_W-1:0] top;
      logic signed [COORD_W-1:0] rect_w;
      logic signed [COORD_W-1:0] rect_h;
      logic [CHAR_W-1:0]         ch;
      logic [RC_W-1:0]           col;
      logic [RC_W-1:0]           row;
   } paint_req_t;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [CHAR_W-1:0]   pixel;
   } paint_answer_t;

   typedef struct packed {
      logic                  is_cfg;
      logic                  typed;
      paint_req_t            req;
      paint_answer_t         answer;
      logic [SIDE_REG_W-1:0] cfg_cols;
      logic [SIDE_REG_W-1:0] cfg_rows;
      logic [CHAR_W-1:0]     cfg_bg;
   } paint_step_t;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   csr_wen    = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_addr   = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;

   // predictor state
   logic [SIDE_REG_W-1:0] cols_setting;
   logic [SIDE_REG_W-1:0] rows_setting;
   logic [CHAR_W-1:0]     backdrop_char;
   logic [CHAR_W-1:0]     canvas_mem [MAX_SIDE*MAX_SIDE];
   paint_answer_t         answer_q [$];

   int   mismatch_count = 0;
   int   quiet_cycles   = 0;
   bit   sender_idle_on = 1'b1;
   logic rsp_idle_on    = 1'b1;
   logic rsp_hold       = 1'b0;
   logic hold_trigger   = 1'b0;

   rectangle_canvas_painter_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   // clamp a side register to the canvas store
   function automatic int used_side(logic [SIDE_REG_W-1:0] reg_value);
      return (reg_value > MAX_SIDE) ? MAX_SIDE : int'(reg_value);
   endfunction

   // apply one request to the canvas copy and return its response
   function automatic paint_answer_t paint_and_answer(paint_req_t rq);
      int            cols;
      int            rows;
      longint        one;
      longint        left;
      longint        top;
      longint        right;
      longint        bottom;
      longint        px;
      longint        py;
      bit            interior;
      bit            hit;
      paint_answer_t ans;
      cols = used_side(cols_setting);
      rows = used_side(rows_setting);
      one  = longint'(ONE_UNIT);
      ans.status = RSP_DONE;
      ans.pixel  = '0;
      case (rq.cmd)
         CMD_CLEAR: begin
            for (int r = 0; r < rows; r++)
               for (int c = 0; c < cols; c++)
                  canvas_mem[r*MAX_SIDE + c] = backdrop_char;
         end
         CMD_DRAW: begin
            left   = longint'($signed(rq.left));
            top    = longint'($signed(rq.top));
            right  = left + longint'($signed(rq.rect_w));
            bottom = top + longint'($signed(rq.rect_h));
            if ($signed(rq.rect_w) < ONE_UNIT || $signed(rq.rect_h) < ONE_UNIT) begin
               ans.status = RSP_REJECT;
            end else begin
               for (int r = 0; r < rows; r++) begin
                  py = longint'(r) * one;
                  interior = rq.outline && (py - one >= top) && (py + one <= bottom);
                  for (int c = 0; c < cols; c++) begin
                     px = longint'(c) * one;
                     if (interior)
                        hit = (px - one < left && px >= left) ||
                              (px <= right && px + one > right);
                     else
                        hit = py >= top && px >= left && py <= bottom && px <= right;
                     if (hit)
                        canvas_mem[r*MAX_SIDE + c] = rq.ch;
                  end
               end
            end
         end
         CMD_READ: begin
            if (int'(rq.col) < cols && int'(rq.row) < rows) begin
               ans.status = RSP_PIXEL;
               ans.pixel  = canvas_mem[int'(rq.row)*MAX_SIDE + int'(rq.col)];
            end
         end
         default: ;
      endcase
      return ans;
   endfunction

   function automatic void report_mismatch(string what, paint_answer_t want);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t: %s: expected status %0d pixel %02h, got status %0d pixel %02h",
                  $time, what, want.status, want.pixel, rsp_tuser, rsp_tdata);
   endfunction

   // directed table row builders
   function automatic paint_step_t read_step(int col, int row);
      paint_step_t s;
      s = '0;
      s.req.cmd = CMD_READ;
      s.req.col = RC_W'(col);
      s.req.row = RC_W'(row);
      return s;
   endfunction

   function automatic paint_step_t draw_step(bit outline, int left, int top,
                                             int rect_w, int rect_h, int ch);
      paint_step_t s;
      s = '0;
      s.req.cmd     = CMD_DRAW;
      s.req.outline = outline;
      s.req.left    = COORD_W'(left);
      s.req.top     = COORD_W'(top);
      s.req.rect_w  = COORD_W'(rect_w);
      s.req.rect_h  = COORD_W'(rect_h);
      s.req.ch      = CHAR_W'(ch);
      return s;
   endfunction

   function automatic paint_step_t plain_step(logic [CMD_W-1:0] cmd);
      paint_step_t s;
      s = '0;
      s.req.cmd = cmd;
      return s;
   endfunction

   function automatic paint_step_t canvas_step(int cols, int rows, int bg);
      paint_step_t s;
      s = '0;
      s.is_cfg   = 1'b1;
      s.cfg_cols = SIDE_REG_W'(cols);
      s.cfg_rows = SIDE_REG_W'(rows);
      s.cfg_bg   = CHAR_W'(bg);
      return s;
   endfunction

   function automatic paint_step_t with_answer(paint_step_t s, logic [STATUS_W-1:0] status,
                                               logic [CHAR_W-1:0] pixel);
      s.typed         = 1'b1;
      s.answer.status = status;
      s.answer.pixel  = pixel;
      return s;
   endfunction

   // random request, shaped so that draws and reads mostly land on the canvas
   function automatic paint_req_t random_request(bit allow_sweep);
      paint_req_t rq;
      int         cols;
      int         rows;
      int         pick;
      int         shape;
      cols = used_side(cols_setting);
      rows = used_side(rows_setting);
      rq.cmd     = CMD_W'($urandom_range(3));
      rq.outline = 1'($urandom_range(1));
      rq.left    = COORD_W'($urandom);
      rq.top     = COORD_W'($urandom);
      rq.rect_w  = COORD_W'($urandom);
      rq.rect_h  = COORD_W'($urandom);
      rq.ch      = CHAR_W'($urandom);
      rq.col     = RC_W'($urandom);
      rq.row     = RC_W'($urandom);
      pick = int'($urandom_range(99));
      if (!allow_sweep)
         pick = pick % 52;
      if (pick < 45) begin
         rq.cmd = CMD_READ;
         if (cols > 0 && rows > 0 && $urandom_range(99) < 80) begin
            rq.col = RC_W'($urandom_range(cols - 1));
            rq.row = RC_W'($urandom_range(rows - 1));
         end
      end else if (pick < 52) begin
         rq.cmd = CMD_UNUSED;
      end else if (pick < 92) begin
         rq.cmd = CMD_DRAW;
         shape = int'($urandom_range(99));
         if (shape < 70) begin
            rq.left   = COORD_W'(-3*ONE_UNIT + int'($urandom_range((cols + 5) * ONE_UNIT)));
            rq.top    = COORD_W'(-3*ONE_UNIT + int'($urandom_range((rows + 5) * ONE_UNIT)));
            rq.rect_w = COORD_W'(ONE_UNIT + int'($urandom_range((cols/2 + 4) * ONE_UNIT)));
            rq.rect_h = COORD_W'(ONE_UNIT + int'($urandom_range((rows/2 + 4) * ONE_UNIT)));
         end else if (shape < 85) begin
            // one side below a whole unit: rejected
            if ($urandom_range(1))
               rq.rect_w = COORD_W'(int'($urandom_range(2*ONE_UNIT - 1)) - ONE_UNIT);
            else
               rq.rect_h = COORD_W'(int'($urandom_range(2*ONE_UNIT - 1)) - ONE_UNIT);
         end
      end else begin
         rq.cmd = CMD_CLEAR;
      end
      return rq;
   endfunction

   // offer one request beat, hold it until taken, then record its response
   task automatic send_request(paint_req_t rq, bit typed, paint_answer_t typed_answer);
      int                     gap;
      logic [REQ_TDATA_W-1:0] beat;
      paint_answer_t          predicted;
      gap = 0;
      while (sender_idle_on && $urandom_range(99) < IDLE_PCT)
         gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      beat = '0;
      beat[REQ_LEFT_LSB   +: COORD_W] = rq.left;
      beat[REQ_TOP_LSB    +: COORD_W] = rq.top;
      beat[REQ_WIDTH_LSB  +: COORD_W] = rq.rect_w;
      beat[REQ_HEIGHT_LSB +: COORD_W] = rq.rect_h;
      beat[REQ_CHAR_LSB   +: CHAR_W]  = rq.ch;
      beat[REQ_COL_LSB    +: RC_W]    = rq.col;
      beat[REQ_ROW_LSB    +: RC_W]    = rq.row;
      req_tdata  <= beat;
      req_tuser  <= {rq.outline, rq.cmd};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      predicted = paint_and_answer(rq);
      answer_q.push_back(typed ? typed_answer : predicted);
   endtask

   // drop valid and wait until every pending response has come back
   task automatic settle();
      req_tvalid <= 1'b0;
      while (answer_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_setting(csr_index_type idx, int value);
      csr_wen   <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      case (idx)
         CSR_CANVAS_WIDTH:  cols_setting  = value[SIDE_REG_W-1:0];
         CSR_CANVAS_HEIGHT: rows_setting  = value[SIDE_REG_W-1:0];
         CSR_BACKGROUND:    backdrop_char = value[CHAR_W-1:0];
         default: ;
      endcase
   endtask

   task automatic program_canvas(int cols, int rows, int bg);
      settle();
      write_setting(CSR_CANVAS_WIDTH, cols);
      write_setting(CSR_CANVAS_HEIGHT, rows);
      write_setting(CSR_BACKGROUND, bg);
      csr_wen <= 1'b0;
   endtask

   // one canvas setting: clear first so every pixel in use is written
   task automatic run_phase(int cols, int rows, int bg, int item_count,
                            int sweep_budget, bit squeeze);
      paint_req_t rq;
      program_canvas(cols, rows, bg);
      rq = random_request(1'b0);
      rq.cmd = CMD_CLEAR;
      send_request(rq, 1'b0, '0);
      if (squeeze)
         hold_trigger <= 1'b1;
      repeat (item_count) begin
         rq = random_request(sweep_budget > 0);
         if (rq.cmd == CMD_DRAW || rq.cmd == CMD_CLEAR)
            sweep_budget--;
         send_request(rq, 1'b0, '0);
      end
   endtask

   // response side: check the beat taken at this edge, then pick the next ready
   always @(posedge clock) begin
      paint_answer_t want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (answer_q.size() == 0) begin
               report_mismatch("beat with nothing pending", 'x);
            end else begin
               want = answer_q.pop_front();
               if (rsp_tuser !== want.status || rsp_tdata !== want.pixel)
                  report_mismatch("response mismatch", want);
            end
         end
         rsp_tready <= !rsp_hold && !(rsp_idle_on && $urandom_range(99) < IDLE_PCT);
      end
   end

   // long response hold-off so the block fills up and stalls its input
   initial begin : rsp_hold_off
      wait (hold_trigger);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || csr_wen || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("rectangle_canvas_painter_top regression: fail");
         $finish;
      end
   end

   initial begin : stimulus
      paint_step_t steps [$];
      cols_setting  = RST_CANVAS_WIDTH;
      rows_setting  = RST_CANVAS_HEIGHT;
      backdrop_char = RST_BACKGROUND;

      // after reset: reads outside the canvas, rejected draws, unused command
      steps.push_back(with_answer(read_step(300, 0), RSP_DONE, 8'h00));
      steps.push_back(with_answer(read_step(511, 511), RSP_DONE, 8'h00));
      steps.push_back(with_answer(draw_step(0, 0, 0, 0, 256, 8'h41), RSP_REJECT, 8'h00));
      steps.push_back(with_answer(draw_step(1, 256, 256, 256, 255, 8'h42),
                                  RSP_REJECT, 8'h00));
      steps.push_back(with_answer(draw_step(0, 524287, -524288, -524288, 524287, 8'hFF),
                                  RSP_REJECT, 8'h00));
      steps.push_back(with_answer(plain_step(CMD_UNUSED), RSP_DONE, 8'h00));
      // small canvas: fill, outline, then probe edges and interior
      steps.push_back(canvas_step(20, 14, 8'h2E));
      steps.push_back(with_answer(plain_step(CMD_CLEAR), RSP_DONE, 8'h00));
      steps.push_back(with_answer(draw_step(0, 'h280, 'h100, 'h540, 'h400, 8'h23),
                                  RSP_DONE, 8'h00));
      steps.push_back(with_answer(draw_step(1, 'hA00, 'h2C0, 'h680, 'h800, 8'h6F),
                                  RSP_DONE, 8'h00));
      steps.push_back(read_step(2, 1));
      steps.push_back(read_step(3, 1));
      steps.push_back(read_step(7, 5));
      steps.push_back(read_step(8, 5));
      steps.push_back(read_step(13, 3));
      steps.push_back(read_step(13, 6));
      steps.push_back(read_step(16, 6));
      steps.push_back(read_step(17, 6));
      steps.push_back(read_step(10, 10));
      steps.push_back(with_answer(read_step(20, 0), RSP_DONE, 8'h00));
      // extreme coordinates: rectangles wholly off the canvas
      steps.push_back(with_answer(draw_step(1, -524288, -524288, 524287, 524287, 8'hFF),
                                  RSP_DONE, 8'h00));
      steps.push_back(with_answer(draw_step(0, 524287, 524287, 524287, 524287, 8'h80),
                                  RSP_DONE, 8'h00));
      // outline larger than the canvas: only its top row lands
      steps.push_back(draw_step(1, -384, -128, 30*256, 'h1200, 8'h00));
      steps.push_back(read_step(5, 0));
      steps.push_back(read_step(19, 13));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (steps[i]) begin
         if (steps[i].is_cfg)
            program_canvas(steps[i].cfg_cols, steps[i].cfg_rows, steps[i].cfg_bg);
         else
            send_request(steps[i].req, steps[i].typed, steps[i].answer);
      end

      run_phase(16, 16, $urandom_range(255), 12, 999, 1'b0);
      // width above the store saturates; single row
      run_phase(1023, 1, 8'h00, 10, 999, 1'b0);
      run_phase(1, 1023, 8'hFF, 10, 999, 1'b0);
      // empty canvas: every read lands outside
      run_phase(0, 9, 8'h2A, 8, 999, 1'b0);
      run_phase(24, 20, 8'h2E, 14, 999, 1'b1);
      // full store: at most one sweep beyond the clear, the rest reads or unused
      run_phase(512, 512, 8'h5A, 8, 1, 1'b0);
      // steady stretch with no idling on either side
      sender_idle_on = 1'b0;
      rsp_idle_on <= 1'b0;
      run_phase(13, 7, $urandom_range(255), 16, 999, 1'b0);

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && answer_q.size() == 0)
         $display("rectangle_canvas_painter_top regression: pass");
      else
         $display("rectangle_canvas_painter_top regression: fail");
      $finish;
   end

endmodule

>>> sim.f
sv/rcp_pkg.sv
sv/rcp_ctrl.sv
sv/rcp_datapath.sv
sv/rectangle_canvas_painter_top.sv
dv/tb_rectangle_canvas_painter_top.sv
